// File: rtl/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Types and constants of the RGB to HSL / HSV pixel converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

	// hue in 1/64 degree: a full circle
	localparam logic [14:0] HUE_FULL = 15'd23040;

	// hue offsets in 1/64 degree, scaled by d in the datapath
	localparam logic [14:0] BASE_RED_WRAP = 15'd23040;
	localparam logic [14:0] BASE_GREEN    = 15'd7680;
	localparam logic [14:0] BASE_BLUE     = 15'd15360;
	localparam logic signed [24:0] HUE_SLOPE = 25'sd3840; // 60 deg * 64

	// divider geometry
	localparam int HUE_QW    = 15;            // hue quotient bits
	localparam int SAT_QW    = 13;            // saturation quotient bits
	localparam int REM_W     = 9;             // partial remainder / divisor bits
	localparam int HUE_AW    = REM_W + HUE_QW;
	localparam int SAT_AW    = REM_W + SAT_QW;
	localparam int DIV_STEPS = 4;             // quotient bits per stage
	localparam int HUE_STEPS_LAST = HUE_QW - 3 * DIV_STEPS;
	localparam int SAT_STEPS_LAST = SAT_QW - 3 * DIV_STEPS;

	// register map, word index
	localparam logic REG_COLOR_SPACE = 1'b0;

	typedef enum logic {
		CS_HSL = 1'b0,
		CS_HSV = 1'b1
	} color_space_t;

	typedef enum logic [1:0] {
		MAX_RED   = 2'd0,
		MAX_GREEN = 2'd1,
		MAX_BLUE  = 2'd2
	} max_sel_t;

	typedef struct packed {
		logic [7:0]        mx;
		logic [7:0]        mn;
		logic [7:0]        d;
		max_sel_t          sel;
		logic signed [8:0] diff;
	} minmax_t;

	typedef struct packed {
		logic [HUE_AW-1:0] hacc;
		logic [REM_W-1:0]  hdiv;
		logic [SAT_AW-1:0] sacc;
		logic [REM_W-1:0]  sdiv;
		logic [8:0]        level;
		logic              grey;
	} div_stage_t;

endpackage

// File: rtl/rgb_to_hsl_hsv_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_hsv_core
// Pipelined RGB to HSL / HSV pixel converter with an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel (red, green, blue) is taken on the pix channel when pix_valid and
//   pix_ready are both high; hue, saturation and level come out on the res
//   channel, one result per pixel, in order.
//   Register color_space (address 0, bit 0) selects HSL (0) or HSV (1).
//   Change it only while no pixel is in flight.
//   Throughput is one pixel per cycle while the receiver keeps res_ready
//   high; the stages are min/max, dividend setup, four stages of the two
//   restoring dividers (up to four quotient bits each) and an output stage.
//   When the receiver holds res_ready low, results stay in the pipeline and
//   empty stages still fill; pix_ready drops only when every stage is full.
//   Reset clears all valid bits and sets color_space to HSL.
// ----------------------------------------------------------------------------
module rgb_to_hsl_hsv_core
	import rgbhsl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel in
	input  logic        pix_valid,
	output logic        pix_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	// result out
	output logic        res_valid,
	input  logic        res_ready,
	output logic [14:0] hue,
	output logic [12:0] saturation,
	output logic [8:0]  level
);

	color_space_t cs_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	minmax_t    mm_d, mm_s1;
	div_stage_t div_d, div_s2, div_s3, div_s4, div_s5, div_s6;
	logic [14:0] hue_s7;
	logic [12:0] sat_s7;
	logic [8:0]  level_s7;

	// ---------------- register port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= CS_HSL;
		end else if (psel && penable && pwrite && paddr[2] == REG_COLOR_SPACE) begin
			cs_q <= color_space_t'(pwdata[0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_COLOR_SPACE) begin
			prdata[0] = cs_q;
		end
	end

	// ---------------- flow control ----------------
	// a stage loads when it is empty or its content moves on
	assign en_s7 = !v_s7 || res_ready;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pix_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// ---------------- stage 1: max, min, hue branch ----------------
	always_comb begin
		mm_d.mx = red;
		mm_d.mn = red;
		if (green > mm_d.mx) mm_d.mx = green;
		if (blue > mm_d.mx)  mm_d.mx = blue;
		if (green < mm_d.mn) mm_d.mn = green;
		if (blue < mm_d.mn)  mm_d.mn = blue;
		mm_d.d = mm_d.mx - mm_d.mn;
		// red wins ties, then green
		if (mm_d.mx == red) begin
			mm_d.sel  = MAX_RED;
			mm_d.diff = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (mm_d.mx == green) begin
			mm_d.sel  = MAX_GREEN;
			mm_d.diff = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			mm_d.sel  = MAX_BLUE;
			mm_d.diff = $signed({1'b0, red}) - $signed({1'b0, green});
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) mm_s1 <= mm_d;
	end

	// ---------------- stage 2: dividends and divisors ----------------
	logic [14:0]        base;
	logic [22:0]        bprod;
	logic signed [24:0] hnum;
	logic [8:0]         sum;
	logic [7:0]         den;

	always_comb begin
		case (mm_s1.sel)
			MAX_RED:   base = mm_s1.diff[8] ? BASE_RED_WRAP : 15'd0;
			MAX_GREEN: base = BASE_GREEN;
			MAX_BLUE:  base = BASE_BLUE;
			default:   base = 15'd0;
		endcase
		bprod = 23'(base) * 23'(mm_s1.d);
		// hue*64*d, already inside one full circle
		hnum = $signed({2'b00, bprod}) + $signed({{16{mm_s1.diff[8]}}, mm_s1.diff}) * HUE_SLOPE;
		sum  = {1'b0, mm_s1.mx} + {1'b0, mm_s1.mn};
		if (cs_q == CS_HSV) begin
			den         = mm_s1.mx;
			div_d.level = {1'b0, mm_s1.mx};
		end else begin
			den         = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
			div_d.level = sum;
		end
		// round to nearest: (2n + d) / (2d)
		div_d.hacc = {hnum[22:0], 1'b0} + {16'd0, mm_s1.d};
		div_d.hdiv = {mm_s1.d, 1'b0};
		div_d.sacc = {1'b0, mm_s1.d, 13'd0} + {14'd0, den};
		div_d.sdiv = {den, 1'b0};
		div_d.grey = (mm_s1.d == 8'd0);
	end

	always_ff @(posedge clk) begin
		if (en_s2) div_s2 <= div_d;
	end

	// ---------------- stages 3-6: restoring division ----------------
	function automatic logic [HUE_AW-1:0] hue_steps(
		input logic [HUE_AW-1:0] acc,
		input logic [REM_W-1:0]  dv,
		input int                n
	);
		logic [REM_W:0]    t;
		logic [HUE_AW-1:0] a;
		a = acc;
		for (int i = 0; i < DIV_STEPS; i++) begin
			if (i < n) begin
				t = {a[HUE_AW-1 -: REM_W], a[HUE_QW-1]};
				if (t >= {1'b0, dv}) begin
					t = t - {1'b0, dv};
					a = {t[REM_W-1:0], a[HUE_QW-2:0], 1'b1};
				end else begin
					a = {t[REM_W-1:0], a[HUE_QW-2:0], 1'b0};
				end
			end
		end
		return a;
	endfunction

	function automatic logic [SAT_AW-1:0] sat_steps(
		input logic [SAT_AW-1:0] acc,
		input logic [REM_W-1:0]  dv,
		input int                n
	);
		logic [REM_W:0]    t;
		logic [SAT_AW-1:0] a;
		a = acc;
		for (int i = 0; i < DIV_STEPS; i++) begin
			if (i < n) begin
				t = {a[SAT_AW-1 -: REM_W], a[SAT_QW-1]};
				if (t >= {1'b0, dv}) begin
					t = t - {1'b0, dv};
					a = {t[REM_W-1:0], a[SAT_QW-2:0], 1'b1};
				end else begin
					a = {t[REM_W-1:0], a[SAT_QW-2:0], 1'b0};
				end
			end
		end
		return a;
	endfunction

	function automatic div_stage_t div_stage(input div_stage_t s, input int nh, input int ns);
		div_stage_t o;
		o      = s;
		o.hacc = hue_steps(s.hacc, s.hdiv, nh);
		o.sacc = sat_steps(s.sacc, s.sdiv, ns);
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (en_s3) div_s3 <= div_stage(div_s2, DIV_STEPS, DIV_STEPS);
		if (en_s4) div_s4 <= div_stage(div_s3, DIV_STEPS, DIV_STEPS);
		if (en_s5) div_s5 <= div_stage(div_s4, DIV_STEPS, DIV_STEPS);
		if (en_s6) div_s6 <= div_stage(div_s5, HUE_STEPS_LAST, SAT_STEPS_LAST);
	end

	// ---------------- stage 7: wrap, grey, output ----------------
	logic [14:0] hq;

	always_comb begin
		hq = div_s6.hacc[HUE_QW-1:0];
		if (hq >= HUE_FULL) hq = hq - HUE_FULL;
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			hue_s7   <= div_s6.grey ? 15'd0 : hq;
			sat_s7   <= div_s6.grey ? 13'd0 : div_s6.sacc[SAT_QW-1:0];
			level_s7 <= div_s6.level;
		end
	end

	assign res_valid  = v_s7;
	assign hue        = hue_s7;
	assign saturation = sat_s7;
	assign level      = level_s7;

	// ---------------- assertions ----------------
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && !res_ready))
		else $error("input stalled while pipeline has room");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (hue < HUE_FULL))
		else $error("hue out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (saturation <= 13'd4096))
		else $error("saturation out of range");

	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && saturation == 13'd0) |-> (hue == 15'd0))
		else $error("grey pixel with nonzero hue");

	a_hsv_level: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && cs_q == CS_HSV) |-> !level[8])
		else $error("HSV level above 255");

endmodule
